// ===== src/smac_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the shadow memory access checker.
// No dependencies; all other files but smac_ram refer to it by scoped names.
package smac_pkg;

  // Window geometry
  localparam int SHADOW_DEPTH  = 4096;
  localparam int GRANULE_SHIFT = 3;
  localparam int MAX_SPAN      = 256;

  // Field widths
  localparam int ADDR_W   = 64;
  localparam int SIZE_W   = 9;
  localparam int SHADOW_W = 8;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;

  // Granule index (addresses the store) and granule count (can hold the depth itself)
  localparam int GI_W = $clog2(SHADOW_DEPTH);
  localparam int GC_W = $clog2(SHADOW_DEPTH + 1);

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POISON   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNPOISON = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_POISON  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_USER    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd3;

  // What the sequencer does with a request once its bounds are known
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SCAN,
    ACT_FILL
  } smac_act_t;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic [ADDR_W-1:0]          start_addr;
    logic [SIZE_W-1:0]          byte_len;
    logic signed [SHADOW_W-1:0] poison_value;
  } smac_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              store_flag;
    logic [ADDR_W-1:0] fault_addr;
    logic [SIZE_W-1:0] fault_size;
  } smac_rsp_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    smac_act_t                act;
    logic [GC_W-1:0]          gstart;
    logic [GC_W-1:0]          gend;
    logic [GI_W-1:0]          glast;
    logic [GRANULE_SHIFT-1:0] lastlow;
    logic                     tail;
    logic [GRANULE_SHIFT-1:0] rem;
  } smac_bound_t;

  typedef struct packed {
    logic                we;
    logic [GI_W-1:0]     waddr;
    logic [SHADOW_W-1:0] wdata;
    logic [GI_W-1:0]     raddr;
  } smac_ram_req_t;

endpackage

// ===== src/smac_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, result and base-register write.
// Depends on smac_pkg for widths.
interface smac_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [smac_pkg::KIND_W-1:0]          kind;
  logic [smac_pkg::ADDR_W-1:0]          start_addr;
  logic [smac_pkg::SIZE_W-1:0]          byte_len;
  logic signed [smac_pkg::SHADOW_W-1:0] poison_value;

  modport source (output valid, kind, start_addr, byte_len, poison_value, input ready);
  modport sink   (input valid, kind, start_addr, byte_len, poison_value, output ready);
endinterface

interface smac_out_if;
  logic                        valid;
  logic                        ready;
  logic [smac_pkg::STAT_W-1:0] status;
  logic                        store_flag;
  logic [smac_pkg::ADDR_W-1:0] fault_addr;
  logic [smac_pkg::SIZE_W-1:0] fault_size;

  modport source (output valid, status, store_flag, fault_addr, fault_size, input ready);
  modport sink   (input valid, status, store_flag, fault_addr, fault_size, output ready);
endinterface

interface smac_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [smac_pkg::ADDR_W-1:0] region_base;

  modport source (output valid, region_base, input ready);
  modport sink   (input valid, region_base, output ready);
endinterface

// ===== src/smac_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module smac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/smac_bound.sv =====
`timescale 1ns / 1ps
// Range classification: size, base and window checks, granule span of a request.
// Depends on smac_pkg.
module smac_bound (
  input  smac_pkg::smac_req_t                req,
  input  logic [smac_pkg::ADDR_W-1:0]        off,
  input  logic                               below,
  output smac_pkg::smac_bound_t              bnd
);

  logic                          is_check;
  logic [smac_pkg::SIZE_W-1:0]   addend;
  logic [smac_pkg::ADDR_W:0]     sum;
  logic [smac_pkg::ADDR_W-1:0]   gfull;
  logic [smac_pkg::ADDR_W-1:0]   depth_w;
  logic                          beyond;
  logic [smac_pkg::GRANULE_SHIFT-1:0] rem;
  logic                          tail;

  // checks end at the last byte, ranges one past it
  always_comb begin
    is_check = req.kind inside {smac_pkg::KIND_LOAD, smac_pkg::KIND_STORE};
    addend   = is_check ? (req.byte_len - 1'b1) : req.byte_len;
    sum      = {1'b0, off} + (smac_pkg::ADDR_W + 1)'(addend);
    gfull    = sum[smac_pkg::ADDR_W-1:0] >> smac_pkg::GRANULE_SHIFT;
    depth_w  = smac_pkg::ADDR_W'(smac_pkg::SHADOW_DEPTH);
    rem      = req.byte_len[smac_pkg::GRANULE_SHIFT-1:0];
    tail     = (req.kind == smac_pkg::KIND_UNPOISON) && (rem != '0);
    if (is_check) begin
      beyond = sum[smac_pkg::ADDR_W] || (gfull >= depth_w);
    end else begin
      beyond = sum[smac_pkg::ADDR_W] || (gfull > depth_w) || (tail && (gfull >= depth_w));
    end

    bnd.gstart  = off[smac_pkg::GRANULE_SHIFT +: smac_pkg::GC_W];
    bnd.gend    = sum[smac_pkg::GRANULE_SHIFT +: smac_pkg::GC_W];
    bnd.glast   = sum[smac_pkg::GRANULE_SHIFT +: smac_pkg::GI_W];
    bnd.lastlow = sum[smac_pkg::GRANULE_SHIFT-1:0];
    bnd.tail    = tail;
    bnd.rem     = rem;

    if (req.byte_len == '0) begin
      bnd.status = smac_pkg::STAT_OK;
      bnd.act    = smac_pkg::ACT_NONE;
    end else if (32'(req.byte_len) > smac_pkg::MAX_SPAN) begin
      bnd.status = smac_pkg::STAT_OUTSIDE;
      bnd.act    = smac_pkg::ACT_NONE;
    end else if (below) begin
      bnd.status = smac_pkg::STAT_USER;
      bnd.act    = smac_pkg::ACT_NONE;
    end else if (beyond) begin
      bnd.status = smac_pkg::STAT_OUTSIDE;
      bnd.act    = smac_pkg::ACT_NONE;
    end else begin
      bnd.status = smac_pkg::STAT_OK;
      bnd.act    = is_check ? smac_pkg::ACT_SCAN : smac_pkg::ACT_FILL;
    end
  end

endmodule

// ===== src/smac_engine.sv =====
`timescale 1ns / 1ps
// Request sequencer: shadow clearing pass, scan and fill over the shadow RAM,
// result register. Depends on smac_pkg and smac_bound.
module smac_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  smac_pkg::smac_req_t         in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output smac_pkg::smac_rsp_t         out_rsp,
  input  logic [smac_pkg::ADDR_W-1:0] region_base,
  output smac_pkg::smac_ram_req_t     ram_req,
  input  logic [smac_pkg::SHADOW_W-1:0] ram_rdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BOUND,
    S_SCAN,
    S_FILL,
    S_DONE
  } state_t;

  state_t                             state_r, state_nxt;
  smac_pkg::smac_req_t                req_r, req_nxt;
  logic [smac_pkg::ADDR_W-1:0]        off_r, off_nxt;
  logic                               below_r, below_nxt;
  logic [smac_pkg::STAT_W-1:0]        status_r, status_nxt;
  logic [smac_pkg::GC_W-1:0]          g_r, g_nxt;
  logic [smac_pkg::GC_W-1:0]          gend_r, gend_nxt;
  logic [smac_pkg::GI_W-1:0]          glast_r, glast_nxt;
  logic [smac_pkg::GRANULE_SHIFT-1:0] lastlow_r, lastlow_nxt;
  logic                               tail_r, tail_nxt;
  logic [smac_pkg::GRANULE_SHIFT-1:0] rem_r, rem_nxt;
  logic                               out_valid_r, out_valid_nxt;
  smac_pkg::smac_rsp_t                rsp_r, rsp_nxt;

  smac_pkg::smac_bound_t              bnd;
  logic [smac_pkg::GC_W-1:0]          g_inc;
  logic [smac_pkg::ADDR_W:0]          diff;
  logic                               scan_last;
  logic                               short_hit;
  logic [smac_pkg::SHADOW_W-1:0]      fill_val;

  smac_bound u_bound (
    .req   (req_r),
    .off   (off_r),
    .below (below_r),
    .bnd   (bnd)
  );

  always_comb begin
    g_inc     = g_r + 1'b1;
    diff      = {1'b0, in_req.start_addr} - {1'b0, region_base};
    scan_last = (g_r[smac_pkg::GI_W-1:0] == glast_r);
    // partial granule: the last byte must lie below the count
    short_hit = $signed({1'b0, smac_pkg::SHADOW_W'(lastlow_r)}) >=
                $signed({ram_rdata[smac_pkg::SHADOW_W-1], ram_rdata});
    fill_val  = (req_r.kind == smac_pkg::KIND_POISON) ? req_r.poison_value : '0;

    state_nxt     = state_r;
    req_nxt       = req_r;
    off_nxt       = off_r;
    below_nxt     = below_r;
    status_nxt    = status_r;
    g_nxt         = g_r;
    gend_nxt      = gend_r;
    glast_nxt     = glast_r;
    lastlow_nxt   = lastlow_r;
    tail_nxt      = tail_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rsp_nxt       = rsp_r;

    ram_req.we    = 1'b0;
    ram_req.waddr = g_r[smac_pkg::GI_W-1:0];
    ram_req.wdata = '0;
    ram_req.raddr = g_inc[smac_pkg::GI_W-1:0];

    case (state_r)
      S_CLEAR: begin
        ram_req.we = 1'b1;
        if (g_r == smac_pkg::GC_W'(smac_pkg::SHADOW_DEPTH - 1)) begin
          g_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          g_nxt = g_inc;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req;
          off_nxt   = diff[smac_pkg::ADDR_W-1:0];
          below_nxt = diff[smac_pkg::ADDR_W];
          state_nxt = S_BOUND;
        end
      end
      S_BOUND: begin
        status_nxt    = bnd.status;
        g_nxt         = bnd.gstart;
        gend_nxt      = bnd.gend;
        glast_nxt     = bnd.glast;
        lastlow_nxt   = bnd.lastlow;
        tail_nxt      = bnd.tail;
        rem_nxt       = bnd.rem;
        ram_req.raddr = bnd.gstart[smac_pkg::GI_W-1:0];
        case (bnd.act)
          smac_pkg::ACT_SCAN: state_nxt = S_SCAN;
          smac_pkg::ACT_FILL: state_nxt = S_FILL;
          default:            state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        // read data belongs to granule g_r; the next granule is already addressed
        if (ram_rdata != '0) begin
          status_nxt = (!scan_last || short_hit) ? smac_pkg::STAT_POISON : smac_pkg::STAT_OK;
          state_nxt  = S_DONE;
        end else if (scan_last) begin
          status_nxt = smac_pkg::STAT_OK;
          state_nxt  = S_DONE;
        end else begin
          g_nxt = g_inc;
        end
      end
      S_FILL: begin
        if (g_r == gend_r) begin
          ram_req.we    = tail_r;
          ram_req.waddr = gend_r[smac_pkg::GI_W-1:0];
          ram_req.wdata = smac_pkg::SHADOW_W'(rem_r);
          state_nxt     = S_DONE;
        end else begin
          ram_req.we    = 1'b1;
          ram_req.wdata = fill_val;
          g_nxt         = g_inc;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt      = 1'b1;
          rsp_nxt.status     = status_r;
          rsp_nxt.store_flag = (req_r.kind == smac_pkg::KIND_STORE);
          rsp_nxt.fault_addr = (status_r != smac_pkg::STAT_OK) ? req_r.start_addr : '0;
          rsp_nxt.fault_size = (status_r != smac_pkg::STAT_OK) ? req_r.byte_len : '0;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      g_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      g_r         <= g_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r     <= req_nxt;
    off_r     <= off_nxt;
    below_r   <= below_nxt;
    status_r  <= status_nxt;
    gend_r    <= gend_nxt;
    glast_r   <= glast_nxt;
    lastlow_r <= lastlow_nxt;
    tail_r    <= tail_nxt;
    rem_r     <= rem_nxt;
    rsp_r     <= rsp_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

// ===== src/shadow_memory_access_checker_core.sv =====
`timescale 1ns / 1ps
// Shadow memory access checker, top level: channels, base register, shadow RAM.
// Depends on smac_pkg, smac_if, smac_ram and smac_engine.
//
// Usage
//   in_ch  : one request per transfer - load check, store check, poison range
//            or unpoison range, with address, size and poison value.
//   out_ch : exactly one result per request, in request order: status,
//            store flag, and address/size of the request when it is reported.
//   cfg_ch : write of region_base; always ready. Write it only while idle.
// Sequencing and throughput
//   One request at a time. A request that needs no shadow access passes from its
//   transfer through the bound state to the result register; a check scans the
//   granules up to the first nonzero one or its last, and a range request writes
//   its whole granules and then, in its last fill step, the tail granule. The input
//   is ready again as soon as the result is loaded.
//   Set by the shadow RAM's single ports: one shadow byte read or written per cycle.
// Reset
//   rst_n is synchronous, active low. Afterwards the shadow RAM is swept to
//   zero, one entry per cycle, all 4096 entries (SHADOW_DEPTH), with in_ch.ready
//   low; base writes are taken during the sweep.
// Stalls
//   A finished result sits in an output register; a new request is accepted
//   while it waits, and that request's result is held back until out_ch frees.
module shadow_memory_access_checker_core (
  input  logic             clk,
  input  logic             rst_n,
  smac_in_if.sink          in_ch,
  smac_out_if.source       out_ch,
  smac_cfg_if.sink         cfg_ch
);

  logic [smac_pkg::ADDR_W-1:0]   region_base_r, region_base_nxt;
  smac_pkg::smac_req_t           in_req;
  smac_pkg::smac_rsp_t           out_rsp;
  smac_pkg::smac_ram_req_t       ram_req;
  logic [smac_pkg::SHADOW_W-1:0] ram_rdata;
  logic                          in_ready;
  logic                          out_valid;

  // Base register: written whenever the config transfer completes
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    region_base_nxt = region_base_r;
    if (cfg_ch.valid) begin
      region_base_nxt = cfg_ch.region_base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
    end else begin
      region_base_r <= region_base_nxt;
    end
  end

  // Request payload gathered into one struct
  always_comb begin
    in_req.kind         = in_ch.kind;
    in_req.start_addr   = in_ch.start_addr;
    in_req.byte_len     = in_ch.byte_len;
    in_req.poison_value = in_ch.poison_value;
  end

  // One shadow byte per granule
  smac_ram #(
    .WIDTH (smac_pkg::SHADOW_W),
    .DEPTH (smac_pkg::SHADOW_DEPTH)
  ) u_shadow (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  smac_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ch.ready),
    .out_rsp     (out_rsp),
    .region_base (region_base_r),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_rsp.status;
  assign out_ch.store_flag = out_rsp.store_flag;
  assign out_ch.fault_addr = out_rsp.fault_addr;
  assign out_ch.fault_size = out_rsp.fault_size;

  // One request in flight: a transfer closes the input until its result is registered
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // Shadow writes only happen in the sweep or in a range request, never while idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> !in_ch.ready)
    else $error("shadow write while idle");

  // A passing result reports no fault address or size
  a_ok_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == smac_pkg::STAT_OK) |->
      (out_ch.fault_addr == '0) && (out_ch.fault_size == '0))
    else $error("ok result carries fault data");

  // Zero-size requests always pass, so a report has a nonzero size
  a_fault_sized: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != smac_pkg::STAT_OK) |-> (out_ch.fault_size != '0))
    else $error("reported access with zero size");

endmodule

// ===== verif/smac_checker.sv =====
`timescale 1ns / 1ps
// Passive checker for the shadow memory access checker: keeps its own shadow and base.
// Depends on smac_pkg and the channel interfaces in smac_if.
module smac_checker (
  input  logic clk,
  input  logic rst_n,
  smac_in_if   in_ch,
  smac_out_if  out_ch,
  smac_cfg_if  cfg_ch,
  output int   outstanding,
  output int   mismatches,
  output int   results_seen,
  output int   poison_hits
);

  logic signed [smac_pkg::SHADOW_W-1:0] shadow_model [smac_pkg::SHADOW_DEPTH];
  logic [smac_pkg::ADDR_W-1:0]          base_reg;
  smac_pkg::smac_rsp_t                  expected_q [$];
  int                                   err_count = 0;
  int                                   seen_count = 0;
  int                                   poison_count = 0;

  // First nonzero shadow byte decides; a partial last granule allows bytes below its count
  function automatic bit span_hits_poison(input logic [smac_pkg::ADDR_W-1:0] off,
                                          input logic [smac_pkg::ADDR_W-1:0] lastoff);
    logic [smac_pkg::ADDR_W-1:0] g;
    logic [smac_pkg::ADDR_W-1:0] glast;
    glast = lastoff >> smac_pkg::GRANULE_SHIFT;
    for (g = off >> smac_pkg::GRANULE_SHIFT; g <= glast; g++) begin
      if (shadow_model[g[smac_pkg::GI_W-1:0]] != '0) begin
        if (g != glast) return 1'b1;
        return int'(lastoff[smac_pkg::GRANULE_SHIFT-1:0]) >=
               int'(shadow_model[g[smac_pkg::GI_W-1:0]]);
      end
    end
    return 1'b0;
  endfunction

  // Expected result of one request; range requests update the shadow copy
  function automatic smac_pkg::smac_rsp_t predict_access(input smac_pkg::smac_req_t req);
    smac_pkg::smac_rsp_t                rsp;
    logic [smac_pkg::STAT_W-1:0]        stat;
    logic [smac_pkg::ADDR_W-1:0]        size64;
    logic [smac_pkg::ADDR_W-1:0]        off;
    logic [smac_pkg::ADDR_W-1:0]        lastoff;
    logic [smac_pkg::ADDR_W-1:0]        gend;
    logic [smac_pkg::ADDR_W-1:0]        g;
    logic [smac_pkg::SHADOW_W-1:0]      fill;
    logic [smac_pkg::GRANULE_SHIFT-1:0] rem;
    bit                                 tail;
    stat   = smac_pkg::STAT_OK;
    size64 = smac_pkg::ADDR_W'(req.byte_len);
    if (req.byte_len == '0) begin
      stat = smac_pkg::STAT_OK;
    end else if (req.byte_len > smac_pkg::MAX_SPAN) begin
      stat = smac_pkg::STAT_OUTSIDE;
    end else if (req.start_addr < base_reg) begin
      stat = smac_pkg::STAT_USER;
    end else begin
      off = req.start_addr - base_reg;
      if (req.kind == smac_pkg::KIND_LOAD || req.kind == smac_pkg::KIND_STORE) begin
        if (off > ~64'd0 - (size64 - 64'd1)) begin
          stat = smac_pkg::STAT_OUTSIDE;
        end else begin
          lastoff = off + size64 - 64'd1;
          if ((lastoff >> smac_pkg::GRANULE_SHIFT) >= 64'(smac_pkg::SHADOW_DEPTH)) begin
            stat = smac_pkg::STAT_OUTSIDE;
          end else if (span_hits_poison(off, lastoff)) begin
            stat = smac_pkg::STAT_POISON;
          end
        end
      end else if (off > ~64'd0 - size64) begin
        stat = smac_pkg::STAT_OUTSIDE;
      end else begin
        gend = (off + size64) >> smac_pkg::GRANULE_SHIFT;
        rem  = size64[smac_pkg::GRANULE_SHIFT-1:0];
        tail = (req.kind == smac_pkg::KIND_UNPOISON) && (rem != '0);
        // partly outside writes nothing
        if (gend > 64'(smac_pkg::SHADOW_DEPTH) ||
            (tail && gend >= 64'(smac_pkg::SHADOW_DEPTH))) begin
          stat = smac_pkg::STAT_OUTSIDE;
        end else begin
          fill = (req.kind == smac_pkg::KIND_POISON) ? req.poison_value : '0;
          for (g = off >> smac_pkg::GRANULE_SHIFT; g < gend; g++) begin
            shadow_model[g[smac_pkg::GI_W-1:0]] = fill;
          end
          if (tail) shadow_model[gend[smac_pkg::GI_W-1:0]] = smac_pkg::SHADOW_W'(rem);
        end
      end
    end
    rsp.status     = stat;
    rsp.store_flag = (req.kind == smac_pkg::KIND_STORE);
    rsp.fault_addr = (stat != smac_pkg::STAT_OK) ? req.start_addr : '0;
    rsp.fault_size = (stat != smac_pkg::STAT_OK) ? req.byte_len : '0;
    return rsp;
  endfunction

  always @(posedge clk) begin
    smac_pkg::smac_req_t req;
    smac_pkg::smac_rsp_t got;
    smac_pkg::smac_rsp_t want;
    if (!rst_n) begin
      foreach (shadow_model[i]) shadow_model[i] = '0;
      base_reg = '0;
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) base_reg = cfg_ch.region_base;
      if (in_ch.valid && in_ch.ready) begin
        req.kind         = in_ch.kind;
        req.start_addr   = in_ch.start_addr;
        req.byte_len     = in_ch.byte_len;
        req.poison_value = in_ch.poison_value;
        expected_q.push_back(predict_access(req));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status     = out_ch.status;
        got.store_flag = out_ch.store_flag;
        got.fault_addr = out_ch.fault_addr;
        got.fault_size = out_ch.fault_size;
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing outstanding: status %0d addr %h",
                 got.status, got.fault_addr);
          err_count++;
        end else begin
          want = expected_q.pop_front();
          seen_count++;
          if (want.status == smac_pkg::STAT_POISON) poison_count++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
          end
          if (got.store_flag !== want.store_flag) begin
            $error("store_flag: expected %0d, got %0d", want.store_flag, got.store_flag);
            err_count++;
          end
          if (got.fault_addr !== want.fault_addr) begin
            $error("fault_addr: expected %h, got %h", want.fault_addr, got.fault_addr);
            err_count++;
          end
          if (got.fault_size !== want.fault_size) begin
            $error("fault_size: expected %0d, got %0d", want.fault_size, got.fault_size);
            err_count++;
          end
        end
      end
    end
    // published after the edge so stimulus reads settled values
    outstanding  <= expected_q.size();
    mismatches   <= err_count;
    results_seen <= seen_count;
    poison_hits  <= poison_count;
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the shadow memory access checker bench: clock, reset, stimulus and verdict.
// Depends on smac_pkg, smac_if, the block under test and smac_checker.
module testbench;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int WINDOW_BYTES = smac_pkg::SHADOW_DEPTH << smac_pkg::GRANULE_SHIFT;
  localparam logic [smac_pkg::ADDR_W-1:0] DIR_BASE = 64'h0000_0000_0001_0000;

  logic clk;
  logic rst_n;

  smac_in_if  in_ch ();
  smac_out_if out_ch ();
  smac_cfg_if cfg_ch ();

  int outstanding;
  int mismatches;
  int results_seen;
  int poison_hits;

  int cycle_count   = 0;
  int hold_request  = 0;   // long back-pressure asked of the receiver, in cycles
  int requests_sent = 0;
  int base_settings = 0;
  bit send_burst    = 1'b0;
  bit take_burst    = 1'b0;
  logic [smac_pkg::ADDR_W-1:0] cur_base = '0;

  shadow_memory_access_checker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  smac_checker access_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .outstanding  (outstanding),
    .mismatches   (mismatches),
    .results_seen (results_seen),
    .poison_hits  (poison_hits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: budget covers the reset sweep plus every request at its slowest, many times over
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls per transfer, zero-stall stretches, and the odd long hold-off
  initial begin
    int stall;
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // One request transfer, after a random gap; valid stays up across back-to-back transfers
  task automatic send_req(input logic [smac_pkg::KIND_W-1:0]   kind,
                          input logic [smac_pkg::ADDR_W-1:0]   addr,
                          input logic [smac_pkg::SIZE_W-1:0]   size,
                          input logic [smac_pkg::SHADOW_W-1:0] pv);
    int gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.start_addr   <= addr;
    in_ch.byte_len     <= size;
    in_ch.poison_value <= pv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Stop offering and wait until every expected result has been transferred
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [smac_pkg::ADDR_W-1:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.region_base <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_base = value;
    base_settings++;
  endtask

  // Mostly short accesses, some up to the span limit, a few empty or oversized
  function automatic logic [smac_pkg::SIZE_W-1:0] pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 3) return '0;
    if (p < 6) begin
      return smac_pkg::SIZE_W'($urandom_range(smac_pkg::MAX_SPAN + 1,
                                              (1 << smac_pkg::SIZE_W) - 1));
    end
    if (p < 70) return smac_pkg::SIZE_W'($urandom_range(1, 16));
    return smac_pkg::SIZE_W'($urandom_range(1, smac_pkg::MAX_SPAN));
  endfunction

  // Random traffic: mostly a range rewrite followed by checks around its edges, rest noise
  task automatic run_traffic(input int n_items);
    int                          target;
    int                          n_checks;
    int                          d;
    logic [smac_pkg::ADDR_W-1:0] o;
    logic [smac_pkg::ADDR_W-1:0] addr;
    logic [smac_pkg::SIZE_W-1:0] s;
    logic [smac_pkg::SIZE_W-1:0] cs;
    target = requests_sent + n_items;
    while (requests_sent < target) begin
      if ($urandom_range(0, 99) < 75) begin
        case ($urandom_range(0, 3))
          0:       o = smac_pkg::ADDR_W'($urandom_range(0, 63));
          1:       o = smac_pkg::ADDR_W'(WINDOW_BYTES - $urandom_range(1, 300));
          default: o = smac_pkg::ADDR_W'($urandom_range(0, WINDOW_BYTES - 1));
        endcase
        if ($urandom_range(0, 1) == 1) o[smac_pkg::GRANULE_SHIFT-1:0] = '0;
        s = pick_size();
        send_req(($urandom_range(0, 1) == 1) ? smac_pkg::KIND_POISON : smac_pkg::KIND_UNPOISON,
                 cur_base + o, s, smac_pkg::SHADOW_W'($urandom));
        n_checks = $urandom_range(2, 6);
        repeat (n_checks) begin
          d  = int'($urandom_range(0, s + 16)) - 8;
          cs = ($urandom_range(0, 3) == 0) ? pick_size()
                                           : smac_pkg::SIZE_W'($urandom_range(1, 16));
          send_req(($urandom_range(0, 1) == 1) ? smac_pkg::KIND_STORE : smac_pkg::KIND_LOAD,
                   cur_base + o + smac_pkg::ADDR_W'(d), cs, smac_pkg::SHADOW_W'($urandom));
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       addr = {$urandom, $urandom};
          1:       addr = ~64'd0 - smac_pkg::ADDR_W'($urandom_range(0, 300));   // end wraps
          default: addr = cur_base + smac_pkg::ADDR_W'($urandom_range(0, WINDOW_BYTES + 512))
                          - 64'd256;
        endcase
        send_req(smac_pkg::KIND_W'($urandom), addr, smac_pkg::SIZE_W'($urandom),
                 smac_pkg::SHADOW_W'($urandom));
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.kind         <= smac_pkg::KIND_LOAD;
    in_ch.start_addr   <= '0;
    in_ch.byte_len     <= '0;
    in_ch.poison_value <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.region_base <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Base write lands during the shadow sweep; requests wait for in_ch.ready
    write_base(DIR_BASE);

    // Directed: empty, oversized, below base, partial granules, signed counts, window edge
    send_req(smac_pkg::KIND_LOAD,     64'd0,             9'd0,   8'h00);  // empty, below base
    send_req(smac_pkg::KIND_STORE,    DIR_BASE,          9'd257, 8'h00);  // oversized
    send_req(smac_pkg::KIND_POISON,   DIR_BASE,          9'd511, 8'h00);
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE - 64'd1,  9'd1,   8'h00);  // user access
    send_req(smac_pkg::KIND_UNPOISON, DIR_BASE - 64'd8,  9'd8,   8'h00);
    send_req(smac_pkg::KIND_POISON,   DIR_BASE + 64'd16, 9'd16,  8'hFF);  // granules 2 and 3
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd16, 9'd1,   8'h00);
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd8,  9'd8,   8'h00);
    send_req(smac_pkg::KIND_STORE,    DIR_BASE + 64'd8,  9'd9,   8'h00);  // spills into poison
    send_req(smac_pkg::KIND_UNPOISON, DIR_BASE + 64'd16, 9'd5,   8'h00);  // tail count 5 only
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd16, 9'd5,   8'h00);
    send_req(smac_pkg::KIND_STORE,    DIR_BASE + 64'd16, 9'd6,   8'h00);
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd20, 9'd1,   8'h00);
    send_req(smac_pkg::KIND_POISON,   DIR_BASE + 64'd40, 9'd8,   8'h80);  // most negative
    send_req(smac_pkg::KIND_POISON,   DIR_BASE + 64'd48, 9'd8,   8'h7F);  // large count
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd48, 9'd8,   8'h00);
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd40, 9'd16,  8'h00);  // poison before last
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd32767, 9'd1, 8'h00); // last byte of window
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd32767, 9'd2, 8'h00); // runs past window
    send_req(smac_pkg::KIND_POISON,   DIR_BASE + 64'd32760, 9'd8, 8'h03);
    send_req(smac_pkg::KIND_UNPOISON, DIR_BASE + 64'd32760, 9'd9, 8'h00); // tail beyond
    send_req(smac_pkg::KIND_LOAD,     DIR_BASE + 64'd32760, 9'd3, 8'h00);
    send_req(smac_pkg::KIND_STORE,    DIR_BASE + 64'd32760, 9'd4, 8'h00);
    send_req(smac_pkg::KIND_STORE,    64'hFFFF_FFFF_FFFF_FFFF, 9'd256, 8'h00);
    send_req(smac_pkg::KIND_STORE,    DIR_BASE,          9'd256, 8'h00);  // full span
    drain();

    // Base at zero: wrap past 2^64 is reachable; long result hold-off mid-phase
    write_base(64'd0);
    run_traffic(160);
    hold_request = 300;
    run_traffic(40);
    run_traffic(120);
    drain();

    // Random base, with a full pause halfway
    write_base({$urandom, $urandom} & ~64'hFFFF);
    run_traffic(150);
    drain();
    run_traffic(150);
    drain();

    // Window ending exactly at the top of the address space
    write_base(64'hFFFF_FFFF_FFFF_8000);
    run_traffic(300);
    drain();

    // Highest base: only the last address is monitored
    write_base(64'hFFFF_FFFF_FFFF_FFFF);
    send_req(smac_pkg::KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 9'd1, 8'h00);
    run_traffic(150);
    drain();

    write_base(64'h0000_0000_0002_0000);
    run_traffic(100);
    hold_request = 200;
    run_traffic(100);
    drain();
    repeat (50) @(posedge clk);

    $display("Sent %0d requests under %0d base settings, with long result hold-offs and pauses.",
             requests_sent, base_settings);
    $display("Checked %0d results, %0d of them poisoned-access reports.",
             results_seen, poison_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== shadow_memory_access_checker_core.f =====
src/smac_pkg.sv
src/smac_if.sv
src/smac_ram.sv
src/smac_bound.sv
src/smac_engine.sv
src/shadow_memory_access_checker_core.sv
verif/smac_checker.sv
verif/testbench.sv
